FILE: src/infix_expression_evaluator_unit_macros.svh
// Assertion macros for the infix expression evaluator.
`ifndef INFIX_EXPRESSION_EVALUATOR_UNIT_MACROS_SVH
`define INFIX_EXPRESSION_EVALUATOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define IEE_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
`define IEE_ASSERT_NORST(label, clk, prop) \
	label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define IEE_ASSERT(label, clk, rst_n, prop)
`define IEE_ASSERT_NORST(label, clk, prop)
`endif
`endif

FILE: src/iee_pkg.sv
// ----------------------------------------------------------------------------
// iee_pkg
// Shared types and constants of the infix expression evaluator.
// ----------------------------------------------------------------------------
`default_nettype none
package iee_pkg;
	localparam int VALUE_STACK_DEPTH = 4;
	localparam int VALUE_BITS = 32;
	localparam int VS_IDX_BITS = $clog2(VALUE_STACK_DEPTH);
	localparam int VS_CNT_BITS = $clog2(VALUE_STACK_DEPTH + 1);
	localparam int DIV_CNT_BITS = $clog2(VALUE_BITS + 1);

	typedef logic [VALUE_BITS-1:0] value_t;
	typedef logic [VS_CNT_BITS-1:0] vcnt_t;

	typedef enum logic [1:0] {OP_ADD = 2'd0, OP_SUB = 2'd1, OP_MUL = 2'd2,
		OP_DIV = 2'd3} op_t;

	typedef enum logic [2:0] {ST_OK = 3'd0, ST_DIV0 = 3'd1, ST_BADCHAR = 3'd2,
		ST_OVERFLOW = 3'd3, ST_STACK = 3'd4} status_t;

	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	// Payload of one input transaction: one character of the formula.
	typedef struct packed {
		logic [7:0] char_code;
		logic       is_last;
	} char_item_t;

	// Payload of one result transaction.
	typedef struct packed {
		value_t     value;
		logic [2:0] status;
	} formula_result_t;

	typedef enum logic [2:0] {S_IDLE, S_PUSHOP, S_APPLY, S_ARITH, S_DIVWAIT,
		S_FINISH, S_OUT} state_t;

	// Controller -> datapath commands.
	typedef struct packed {
		logic load_char;    // capture input character
		logic do_digit;     // accumulate a digit
		logic push_operand; // push pending operand
		logic start_apply;  // pop two values, start arithmetic
		logic arith_done;   // write arithmetic result back
		logic push_op;      // push the captured operator
		logic bad_char;     // latch bad character
		logic load_result;  // build output result
		logic clear;        // return to reset state
	} iee_cmd_t;

	// Datapath -> controller status.
	typedef struct packed {
		logic is_digit;
		logic is_op;
		logic is_last;
		logic err;
		logic op_nonempty;
		logic top_ge;       // top operator precedence >= incoming
		logic div_busy;
	} iee_stat_t;
endpackage
`default_nettype wire

FILE: src/iee_stream_if.sv
// ----------------------------------------------------------------------------
// iee_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
`default_nettype none
interface iee_stream_if #(parameter type payload_t = logic);
	logic valid;
	logic ready;
	payload_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: src/infix_expression_evaluator_unit.sv
// ----------------------------------------------------------------------------
// infix_expression_evaluator_unit
// Streaming shunting-yard evaluator of + - * / formulas, one character each.
// ----------------------------------------------------------------------------
// Takes one ASCII character per input transaction and gives one result
// transaction (value, status) after the character marked is_last. A digit
// is accumulated in S_PUSHOP; an operator pushes the pending operand, then
// applies each stacked operator of equal or higher precedence (S_APPLY,
// S_ARITH, S_DIVWAIT) before it is stacked, a divide waiting on the restoring
// divider that produces one quotient bit per cycle. On the character marked
// is_last the unit pushes the pending operand, applies every remaining
// operator the same way, builds the result and holds it until the result
// transaction is taken. The next character is taken only after the previous
// one and any pending result transaction are finished. After an error the
// latched status is reported with value 0, and the unit returns to its reset
// state after each result.
`default_nettype none
module infix_expression_evaluator_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	iee_stream_if.sink in_ch,
	iee_stream_if.source out_ch
);
	import iee_pkg::*;

	iee_cmd_t cmd;
	iee_stat_t stat;
	value_t value;
	logic [2:0] status;

	// Controller: sequences the per-character work.
	iee_controller u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.stat(stat), .cmd(cmd)
	);

	// Datapath: stacks, accumulator, arithmetic and result register.
	iee_datapath u_dp (
		.clk(clk), .arst_n(arst_n),
		.char_code(in_ch.data.char_code), .is_last(in_ch.data.is_last),
		.cmd(cmd), .stat(stat), .value(value), .status(status)
	);

	assign out_ch.data.value = value;
	assign out_ch.data.status = status;
endmodule
`default_nettype wire

FILE: src/iee_divider.sv
// ----------------------------------------------------------------------------
// iee_divider
// Restoring signed divider, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
`default_nettype none
module iee_divider (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire iee_pkg::value_t dividend,
	input  wire iee_pkg::value_t divisor,
	output logic busy,
	output iee_pkg::value_t quotient
);
	import iee_pkg::*;
	`include "infix_expression_evaluator_unit_macros.svh"

	logic [DIV_CNT_BITS-1:0] cnt_q;
	value_t rem_q, quo_q, dvs_q;
	logic neg_q;
	logic [VALUE_BITS:0] trial;

	assign trial = {rem_q, quo_q[VALUE_BITS-1]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= DIV_CNT_BITS'(VALUE_BITS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend[VALUE_BITS-1] ? value_t'(-dividend) : dividend;
			dvs_q <= divisor[VALUE_BITS-1] ? value_t'(-divisor) : divisor;
			neg_q <= dividend[VALUE_BITS-1] ^ divisor[VALUE_BITS-1];
		end else if (cnt_q != '0) begin
			if (!trial[VALUE_BITS]) begin
				rem_q <= trial[VALUE_BITS-1:0];
				quo_q <= {quo_q[VALUE_BITS-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[VALUE_BITS-2:0], quo_q[VALUE_BITS-1]};
				quo_q <= {quo_q[VALUE_BITS-2:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != '0);
	assign quotient = neg_q ? value_t'(-quo_q) : quo_q;

	`IEE_ASSERT(a_div_start_idle, clk, arst_n, start |-> !busy)
	`IEE_ASSERT(a_div_runs, clk, arst_n, start |=> busy)
	`IEE_ASSERT(a_div_count, clk, arst_n, busy |=> cnt_q == $past(cnt_q) - 1'b1)
endmodule
`default_nettype wire

FILE: src/iee_datapath.sv
// ----------------------------------------------------------------------------
// iee_datapath
// Operand accumulator, operator and value stacks, arithmetic and error latch.
// ----------------------------------------------------------------------------
`default_nettype none
module iee_datapath (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic [7:0] char_code,
	input  wire logic is_last,
	input  wire iee_pkg::iee_cmd_t cmd,
	output iee_pkg::iee_stat_t stat,
	output iee_pkg::value_t value,
	output logic [2:0] status
);
	import iee_pkg::*;
	`include "infix_expression_evaluator_unit_macros.svh"

	localparam value_t MAXPOS = {1'b0, {(VALUE_BITS-1){1'b1}}};

	logic [7:0] char_q;
	logic last_q;
	value_t acc_q;
	logic seen_q;
	op_t ops_q [2];
	logic [1:0] opc_q;
	value_t vs_q [VALUE_STACK_DEPTH];
	vcnt_t vc_q;
	status_t err_q;
	value_t a_q, b_q;
	op_t aop_q;
	value_t mul_s1;
	value_t out_q;
	status_t outst_q;

	op_t in_op, top_op;
	logic [3:0] digit;
	logic ovf;
	value_t ax10, res, fetch_a, fetch_b;
	logic div_busy;
	value_t div_q;

	always_comb begin
		unique case (char_q)
			CH_PLUS: in_op = OP_ADD;
			CH_MINUS: in_op = OP_SUB;
			CH_STAR: in_op = OP_MUL;
			default: in_op = OP_DIV;
		endcase
	end

	assign top_op = ops_q[opc_q[0] ^ 1'b1];
	assign digit = 4'(char_q - CH_ZERO);
	assign ax10 = (acc_q << 3) + (acc_q << 1);
	// acc > (MAXPOS - d)/10  <=>  acc*10 + d > MAXPOS, with acc <= MAXPOS/10 bound
	assign ovf = (acc_q > MAXPOS / 10) ||
		({1'b0, ax10} + {{VALUE_BITS{1'b0}}, 1'b0} + (VALUE_BITS+1)'(digit)
		> {1'b0, MAXPOS});

	assign fetch_b = (vc_q >= vcnt_t'(1)) ? vs_q[VS_IDX_BITS'(vc_q - 1'b1)] : '0;
	assign fetch_a = (vc_q >= vcnt_t'(2)) ? vs_q[VS_IDX_BITS'(vc_q - 2'd2)] : '0;

	iee_divider u_div (
		.clk(clk), .arst_n(arst_n),
		.start(cmd.start_apply && top_op == OP_DIV),
		.dividend(fetch_a), .divisor(fetch_b),
		.busy(div_busy), .quotient(div_q)
	);

	always_comb begin
		case (aop_q)
			OP_ADD: res = a_q + b_q;
			OP_SUB: res = a_q - b_q;
			OP_MUL: res = mul_s1;
			default: res = (b_q == '0) ? '0 : div_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_char) begin
			char_q <= char_code;
			last_q <= is_last;
		end
		if (cmd.start_apply) begin
			a_q <= fetch_a;
			b_q <= fetch_b;
			aop_q <= top_op;
		end
		mul_s1 <= a_q * b_q;
		if (cmd.push_op && opc_q < 2'd2) begin
			ops_q[opc_q[0]] <= in_op;
		end
		if (cmd.push_operand && vc_q < vcnt_t'(VALUE_STACK_DEPTH)) begin
			vs_q[VS_IDX_BITS'(vc_q)] <= seen_q ? acc_q : '0;
		end else if (cmd.arith_done) begin
			vs_q[VS_IDX_BITS'(vc_q)] <= res;
		end
		if (cmd.load_result) begin
			out_q <= (err_q == ST_OK && vc_q != '0) ?
				vs_q[VS_IDX_BITS'(vc_q - 1'b1)] : '0;
			outst_q <= err_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			seen_q <= 1'b0;
			opc_q <= '0;
			vc_q <= '0;
			err_q <= ST_OK;
		end else if (cmd.clear) begin
			acc_q <= '0;
			seen_q <= 1'b0;
			opc_q <= '0;
			vc_q <= '0;
			err_q <= ST_OK;
		end else begin
			if (cmd.do_digit) begin
				if (ovf) begin
					err_q <= ST_OVERFLOW;
				end else begin
					acc_q <= ax10 + value_t'(digit);
					seen_q <= 1'b1;
				end
			end
			if (cmd.bad_char) begin
				err_q <= ST_BADCHAR;
			end
			if (cmd.push_operand) begin
				acc_q <= '0;
				seen_q <= 1'b0;
				if (vc_q < vcnt_t'(VALUE_STACK_DEPTH)) begin
					vc_q <= vc_q + 1'b1;
				end else begin
					err_q <= ST_STACK;
				end
			end
			if (cmd.push_op) begin
				if (opc_q < 2'd2) begin
					opc_q <= opc_q + 1'b1;
				end else begin
					err_q <= ST_STACK;
				end
			end
			if (cmd.start_apply) begin
				opc_q <= opc_q - 1'b1;
				if (vc_q < vcnt_t'(2)) begin
					vc_q <= '0;
					err_q <= ST_STACK;
				end else begin
					vc_q <= vc_q - 2'd2;
					if (top_op == OP_DIV && fetch_b == '0) begin
						err_q <= ST_DIV0;
					end
				end
			end
			// after an underflow the error latch blocks further use, so the
			// result write may simply land at the decremented count
			if (cmd.arith_done && err_q == ST_OK) begin
				vc_q <= vc_q + 1'b1;
			end
		end
	end

	assign stat.is_digit = (char_q >= CH_ZERO) && (char_q <= CH_NINE);
	assign stat.is_op = (char_q == CH_PLUS) || (char_q == CH_MINUS) ||
		(char_q == CH_STAR) || (char_q == CH_SLASH);
	assign stat.is_last = last_q;
	assign stat.err = (err_q != ST_OK);
	assign stat.op_nonempty = (opc_q != '0);
	assign stat.top_ge = top_op[1] >= in_op[1];
	assign stat.div_busy = div_busy;
	assign value = out_q;
	assign status = outst_q;

	`IEE_ASSERT(a_opc_bound, clk, arst_n, opc_q <= 2'd2)
	`IEE_ASSERT(a_vc_bound, clk, arst_n, vc_q <= vcnt_t'(VALUE_STACK_DEPTH))
	`IEE_ASSERT(a_err_holds, clk, arst_n, (err_q != ST_OK && !cmd.clear) |=> err_q == $past(err_q))
endmodule
`default_nettype wire

FILE: src/iee_controller.sv
// ----------------------------------------------------------------------------
// iee_controller
// Sequencer for one character: push, apply loop, finish and result handoff.
// ----------------------------------------------------------------------------
`default_nettype none
module iee_controller (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  wire logic out_ready,
	input  wire iee_pkg::iee_stat_t stat,
	output iee_pkg::iee_cmd_t cmd
);
	import iee_pkg::*;
	`include "infix_expression_evaluator_unit_macros.svh"

	state_t state_q, state_d;
	logic finishing_q;
	logic outv_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && in_ready) state_d = S_PUSHOP;
			end
			S_PUSHOP: begin
				if (!stat.err && stat.is_op) state_d = S_APPLY;
				else if (stat.is_last) state_d = S_FINISH;
				else state_d = S_IDLE;
			end
			S_APPLY: begin
				if (!stat.err && stat.op_nonempty && (finishing_q || stat.top_ge)) begin
					state_d = S_ARITH;
				end else if (finishing_q) begin
					state_d = S_OUT;
				end else if (stat.is_last) begin
					state_d = S_FINISH;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_ARITH: state_d = S_DIVWAIT;
			S_DIVWAIT: begin
				if (!stat.div_busy) state_d = S_APPLY;
			end
			S_FINISH: state_d = S_APPLY;
			S_OUT: begin
				if (!outv_q) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: cmd.load_char = in_valid && in_ready;
			S_PUSHOP: begin
				if (!stat.err) begin
					cmd.do_digit = stat.is_digit;
					cmd.bad_char = !stat.is_digit && !stat.is_op;
					cmd.push_operand = stat.is_op;
				end
			end
			S_APPLY: begin
				if (!stat.err && stat.op_nonempty && (finishing_q || stat.top_ge)) begin
					cmd.start_apply = 1'b1;
				end else if (finishing_q) begin
					cmd.load_result = 1'b1;
					cmd.clear = 1'b1;
				end else if (!stat.err) begin
					cmd.push_op = 1'b1;
				end
			end
			S_DIVWAIT: cmd.arith_done = !stat.div_busy;
			S_FINISH: cmd.push_operand = !stat.err;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			finishing_q <= 1'b0;
			outv_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_FINISH) finishing_q <= 1'b1;
			else if (state_q == S_IDLE) finishing_q <= 1'b0;
			if (cmd.load_result) outv_q <= 1'b1;
			else if (out_ready) outv_q <= 1'b0;
		end
	end

	assign in_ready = (state_q == S_IDLE) && !outv_q;
	assign out_valid = outv_q;

	`IEE_ASSERT(a_ready_idle, clk, arst_n, in_ready |-> state_q == S_IDLE)
	`IEE_ASSERT(a_out_hold, clk, arst_n, (out_valid && !out_ready) |=> out_valid)
	`IEE_ASSERT(a_div_wait, clk, arst_n, state_q == S_ARITH |=> state_q == S_DIVWAIT)
endmodule
`default_nettype wire

FILE: dv/infix_expression_evaluator_unit_tb.sv
// ----------------------------------------------------------------------------
// infix_expression_evaluator_unit_tb
// Self-checking bench for the streaming infix formula evaluator.
// ----------------------------------------------------------------------------
// Feeds formulas one character per transaction. Most are well formed with
// random operands and operators; the rest carry bad characters, missing
// operands and overflowing operands. A predictor follows each accepted
// character and queues the result of every finished formula. A monitor
// compares each result transaction with the oldest queued result. The run
// goes through phases with different amounts of sender idling and receiver
// stalling, a long receiver hold-off and a full drain of the unit.
`default_nettype none
module infix_expression_evaluator_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import iee_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int LONG_HOLD = 600;

	logic clk;
	logic arst_n;

	iee_stream_if #(.payload_t(char_item_t)) in_ch();
	iee_stream_if #(.payload_t(formula_result_t)) out_ch();

	infix_expression_evaluator_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	char_item_t      char_q[$];
	formula_result_t result_q[$];
	int              idle_pct;
	int              stall_pct;
	logic            hold_req;
	logic            hold_done;
	int              hold_cnt;
	int              fail_count;
	int              quiet_cycles;

	// Shadow state of the evaluator
	logic [31:0] acc;
	logic        have_digit;
	op_t         ops[2];
	int          op_cnt;
	logic [31:0] vals[VALUE_STACK_DEPTH];
	int          val_cnt;
	status_t     err;

	function automatic void clear_shadow();
		acc = '0;
		have_digit = 1'b0;
		op_cnt = 0;
		val_cnt = 0;
		err = ST_OK;
	endfunction

	function automatic void flag(status_t code);
		if (err == ST_OK)
			err = code;
	endfunction

	function automatic void push_val(logic [31:0] v);
		if (val_cnt >= VALUE_STACK_DEPTH) begin
			flag(ST_STACK);
			return;
		end
		vals[val_cnt] = v;
		val_cnt++;
	endfunction

	function automatic logic [31:0] pop_val();
		if (val_cnt == 0) begin
			flag(ST_STACK);
			return '0;
		end
		val_cnt--;
		return vals[val_cnt];
	endfunction

	// Signed division truncating toward zero, done on magnitudes
	function automatic logic [31:0] trunc_div(logic [31:0] a, logic [31:0] b);
		logic [31:0] ma;
		logic [31:0] mb;
		logic [31:0] q;
		ma = a[31] ? -a : a;
		mb = b[31] ? -b : b;
		q = ma / mb;
		return (a[31] != b[31]) ? -q : q;
	endfunction

	function automatic void apply_op();
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] r;
		op_t         op;
		if (op_cnt == 0)
			return;
		op_cnt--;
		op = ops[op_cnt];
		b = pop_val();
		a = pop_val();
		case (op)
			OP_ADD: r = a + b;
			OP_SUB: r = a - b;
			OP_MUL: r = a * b;
			default: begin
				if (b == 0) begin
					flag(ST_DIV0);
					r = '0;
				end else begin
					r = trunc_div(a, b);
				end
			end
		endcase
		push_val(r);
	endfunction

	function automatic void push_operand();
		push_val(have_digit ? acc : 32'd0);
		acc = '0;
		have_digit = 1'b0;
	endfunction

	function automatic void take_op(op_t op);
		push_operand();
		while (err == ST_OK && op_cnt > 0 && ops[op_cnt-1][1] >= op[1])
			apply_op();
		if (op_cnt >= 2) begin
			flag(ST_STACK);
			return;
		end
		ops[op_cnt] = op;
		op_cnt++;
	endfunction

	// Advance the shadow state by one character; queue a result on the last one
	function automatic void predict_char(char_item_t it);
		logic [31:0]     d;
		formula_result_t res;
		if (err == ST_OK) begin
			if (it.char_code >= CH_ZERO && it.char_code <= CH_NINE) begin
				d = it.char_code - CH_ZERO;
				if (acc > (32'h7FFF_FFFF - d) / 10)
					flag(ST_OVERFLOW);
				else begin
					acc = acc * 10 + d;
					have_digit = 1'b1;
				end
			end else if (it.char_code == CH_PLUS)
				take_op(OP_ADD);
			else if (it.char_code == CH_MINUS)
				take_op(OP_SUB);
			else if (it.char_code == CH_STAR)
				take_op(OP_MUL);
			else if (it.char_code == CH_SLASH)
				take_op(OP_DIV);
			else
				flag(ST_BADCHAR);
		end
		if (!it.is_last)
			return;
		res.value = '0;
		if (err == ST_OK) begin
			push_operand();
			while (err == ST_OK && op_cnt > 0)
				apply_op();
			if (err == ST_OK && val_cnt > 0)
				res.value = vals[val_cnt-1];
		end
		res.status = err;
		if (err != ST_OK)
			res.value = '0;
		result_q = {result_q, res};
		clear_shadow();
	endfunction

	// Queue a formula given as text; the last character carries the end mark
	task automatic queue_text(string s);
		char_item_t it;
		for (int i = 0; i < s.len(); i++) begin
			it.char_code = s[i];
			it.is_last = (i == s.len() - 1);
			char_q = {char_q, it};
		end
	endtask

	function automatic string rand_operand();
		string s;
		int    n;
		case ($urandom_range(9))
			0: n = 0;                   // missing operand
			1: n = 10;                  // near or past the overflow bound
			default: n = $urandom_range(1, 4);
		endcase
		s = "";
		for (int i = 0; i < n; i++)
			s = {s, string'(byte'(CH_ZERO + $urandom_range(9)))};
		if (n == 10 && $urandom_range(1))
			s = "2147483647";
		return s;
	endfunction

	task automatic queue_random_formula();
		string s;
		byte   opc[4];
		int    n;
		opc = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
		n = $urandom_range(1, 6);
		s = "";
		for (int i = 0; i < n; i++) begin
			if (i > 0)
				s = {s, string'(opc[$urandom_range(3)])};
			s = {s, rand_operand()};
		end
		// Noise: cut the formula at a random point and put any byte there, or append any byte
		if ($urandom_range(9) == 0)
			s = {s.substr(0, $urandom_range(s.len())-1),
				string'(byte'($urandom_range(255))), s.substr(0, -1)};
		if (s.len() == 0 || $urandom_range(19) == 0)
			s = {s, string'(byte'($urandom_range(255)))};
		queue_text(s);
	endtask

	task automatic run_random(int n_chars);
		int target;
		target = char_q.size() + n_chars;
		while (char_q.size() < target)
			queue_random_formula();
	endtask

	task automatic drain();
		while (char_q.size() != 0 || in_ch.valid || result_q.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Driver: predict on each accepted transaction, then offer the next character
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data <= '0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				predict_char(in_ch.data);
			if (!in_ch.valid || in_ch.ready) begin
				if (char_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
					in_ch.data <= char_q.pop_front();
					in_ch.valid <= 1'b1;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stalls, plus one counted hold-off when requested
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			hold_cnt <= 0;
			hold_done <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_cnt <= LONG_HOLD;
			hold_done <= 1'b1;
			out_ch.ready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Monitor: compare each result transaction with the oldest prediction
	always @(posedge clk) begin
		formula_result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (result_q.size() == 0) begin
				$error("result transaction with no prediction: value %0d status %0d",
					$signed(out_ch.data.value), out_ch.data.status);
				fail_count++;
			end else begin
				want = result_q.pop_front();
				if (out_ch.data.value !== want.value) begin
					$error("value: expected %0d, got %0d", $signed(want.value),
						$signed(out_ch.data.value));
					fail_count++;
				end
				if (out_ch.data.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status,
						out_ch.data.status);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: count cycles without any transaction on either channel
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("** infix_expression_evaluator_unit: FAILED **");
			$finish;
		end
	end

	initial begin
		idle_pct = 0;
		stall_pct = 0;
		hold_req = 1'b0;
		clear_shadow();
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed formulas: extremes, every operator, division by zero, bad characters, overflow
		queue_text("7");
		queue_text("2147483647");
		queue_text("2147483648");
		queue_text("1+2*3-8/2");
		queue_text("9-4-3");
		queue_text("100/7/2");
		queue_text("0-7/2");
		queue_text("5/0");
		queue_text("65536*65536+1");
		queue_text("2147483647*2");
		queue_text("*3");
		queue_text("+");
		queue_text("4-");
		queue_text("1a+2");
		queue_text("3+4x");
		queue_text({"12", string'(byte'(8'hFF))});
		queue_text("1+2*3/4-5");
		drain();

		// No idling
		run_random(350);
		drain();
		// Sender idle
		idle_pct = 53;
		run_random(350);
		drain();
		// Receiver stalling, with one long hold-off while the sender keeps going
		idle_pct = 0;
		stall_pct = 53;
		hold_req = 1'b1;
		run_random(350);
		drain();
		// Both
		idle_pct = 31;
		stall_pct = 31;
		run_random(350);
		drain();
		idle_pct = 0;
		stall_pct = 0;
		run_random(150);
		drain();

		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("** infix_expression_evaluator_unit: PASSED **");
		else
			$display("** infix_expression_evaluator_unit: FAILED **");
		$finish;
	end
endmodule
`default_nettype wire
